// ===== sv/vector_rotate_about_point_core_macros.svh =====
// Assertion macros for the rotate-about-point RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef VECTOR_ROTATE_ABOUT_POINT_CORE_MACROS_SVH
`define VECTOR_ROTATE_ABOUT_POINT_CORE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define VRAP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define VRAP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VRAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vrap_pkg.sv =====
// Shared constants, types and the arctangent table of the rotate-about-point core.
// No dependencies; every module file imports this package.
package vrap_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int NUM_STAGES    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam int ANGLE_SHIFT_RAW = 32 - ANGLE_BITS;
  localparam int ANGLE_SHIFT     = (ANGLE_SHIFT_RAW < 0) ? 0 :
                                   ((ANGLE_SHIFT_RAW > 31) ? 31 : ANGLE_SHIFT_RAW);
  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << ANGLE_SHIFT) - 32'd1);
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  localparam int COORD_W = 32;
  localparam int TURN_W  = 16;
  localparam int MAG_W   = COORD_W + 1;
  localparam int PROD_W  = MAG_W + 32;
  localparam int PRE_W   = PROD_W - 16;
  localparam int XY_W    = 52;
  localparam int Z_W     = 34;
  localparam int RND_W   = XY_W - 16;
  localparam int SUM_W   = RND_W + 1;
  localparam int IN_W    = 4 * COORD_W + TURN_W;
  localparam int OUT_W   = 2 * COORD_W;

  localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;
  localparam logic [15:0] ROUND_HALF = 16'h8000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [XY_W-1:0]    xy_t;
  typedef logic signed [Z_W-1:0]     angle_t;

  typedef struct packed {
    xy_t    x;
    xy_t    y;
    angle_t z;
    coord_t pivot_x;
    coord_t pivot_y;
  } item_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/vector_rotate_about_point_core.sv =====
// Throughput: one beat per cycle while the output buffer has room; the unrolled CORDIC chain holds one item per stage.
// Input ready depends only on the two-entry output buffer, so a waiting result
// does not stop intake until that buffer is full.
// Reset (rst_ni low, asynchronous) clears all valid bits and empties the output buffer.
module vector_rotate_about_point_core import vrap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // point_x [31:0], point_y [63:32], pivot_x [95:64], pivot_y [127:96],
  // turn_angle [143:128]
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // rotated_x [31:0], rotated_y [63:32]
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  logic  en;
  logic  pre_valid, cor_valid;
  item_t pre_item, cor_item;

  assign s_axis_tready_o = en;

  vrap_prescale u_prescale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid_i),
    .point_x_i    (s_axis_tdata_i[COORD_W-1:0]),
    .point_y_i    (s_axis_tdata_i[2*COORD_W-1:COORD_W]),
    .pivot_x_i    (s_axis_tdata_i[3*COORD_W-1:2*COORD_W]),
    .pivot_y_i    (s_axis_tdata_i[4*COORD_W-1:3*COORD_W]),
    .turn_angle_i (s_axis_tdata_i[IN_W-1:4*COORD_W]),
    .valid_o      (pre_valid),
    .item_o       (pre_item)
  );

  vrap_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pre_valid),
    .item_i  (pre_item),
    .valid_o (cor_valid),
    .item_o  (cor_item)
  );

  vrap_finish u_finish (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (cor_valid),
    .item_i    (cor_item),
    .room_o    (en),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== sv/vrap_prescale.sv =====
// Front end: offset from the pivot, half-turn angle reduction and gain prescale.
// Three register stages; depends on vrap_pkg.
module vrap_prescale import vrap_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  coord_t              point_x_i,
  input  coord_t              point_y_i,
  input  coord_t              pivot_x_i,
  input  coord_t              pivot_y_i,
  input  logic [TURN_W-1:0]   turn_angle_i,
  output logic                valid_o,
  output item_t               item_o
);

  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    angle_t           z;
    coord_t           pivot_x;
    coord_t           pivot_y;
  } mag_t;

  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    angle_t            z;
    coord_t            pivot_x;
    coord_t            pivot_y;
  } prod_t;

  logic [2:0]         valid_q;
  mag_t               mag_d, mag_q;
  prod_t              prod_d, prod_q;
  item_t              item_d, item_q;
  logic [MAG_W-1:0]   diff_x, diff_y;
  logic [31:0]        angle_full, angle_red, angle_probe;
  logic               flip;
  logic [PROD_W-1:0]  rnd_x, rnd_y;
  logic [PRE_W-1:0]   pre_x, pre_y;
  xy_t                ext_x, ext_y;

  always_comb begin
    diff_x = {point_x_i[COORD_W-1], point_x_i} - {pivot_x_i[COORD_W-1], pivot_x_i};
    diff_y = {point_y_i[COORD_W-1], point_y_i} - {pivot_y_i[COORD_W-1], pivot_y_i};
    angle_full  = {turn_angle_i, {(32 - TURN_W){1'b0}}} & ANGLE_MASK;
    angle_probe = angle_full + QUARTER_TURN;
    flip        = angle_probe[31];
    angle_red   = flip ? (angle_full ^ HALF_TURN) : angle_full;

    mag_d.neg_x   = diff_x[MAG_W-1] ^ flip;
    mag_d.neg_y   = diff_y[MAG_W-1] ^ flip;
    mag_d.mag_x   = diff_x[MAG_W-1] ? (~diff_x + MAG_W'(1)) : diff_x;
    mag_d.mag_y   = diff_y[MAG_W-1] ? (~diff_y + MAG_W'(1)) : diff_y;
    mag_d.z       = {{(Z_W - 32){angle_red[31]}}, angle_red};
    mag_d.pivot_x = pivot_x_i;
    mag_d.pivot_y = pivot_y_i;
  end

  always_comb begin
    prod_d.neg_x   = mag_q.neg_x;
    prod_d.neg_y   = mag_q.neg_y;
    prod_d.prod_x  = PROD_W'(mag_q.mag_x) * PROD_W'(INV_GAIN);
    prod_d.prod_y  = PROD_W'(mag_q.mag_y) * PROD_W'(INV_GAIN);
    prod_d.z       = mag_q.z;
    prod_d.pivot_x = mag_q.pivot_x;
    prod_d.pivot_y = mag_q.pivot_y;
  end

  always_comb begin
    rnd_x = prod_q.prod_x + PROD_W'(ROUND_HALF);
    rnd_y = prod_q.prod_y + PROD_W'(ROUND_HALF);
    pre_x = rnd_x[PROD_W-1:16];
    pre_y = rnd_y[PROD_W-1:16];
    ext_x = signed'({{(XY_W - PRE_W){1'b0}}, pre_x});
    ext_y = signed'({{(XY_W - PRE_W){1'b0}}, pre_y});
    item_d.x       = prod_q.neg_x ? -ext_x : ext_x;
    item_d.y       = prod_q.neg_y ? -ext_y : ext_y;
    item_d.z       = prod_q.z;
    item_d.pivot_x = prod_q.pivot_x;
    item_d.pivot_y = prod_q.pivot_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      prod_q <= prod_d;
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q[2];
  assign item_o  = item_q;

endmodule

// ===== sv/vrap_cordic.sv =====
// Unrolled CORDIC rotator, one register stage per micro-rotation.
// Depends on vrap_pkg for the stage count, item type and arctangent table.
module vrap_cordic import vrap_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o
);

  logic [NUM_STAGES-1:0] valid_q;
  item_t                 stage_d [NUM_STAGES];
  item_t                 stage_q [NUM_STAGES];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    item_t  src;
    logic   src_v;
    xy_t    xs, ys;
    angle_t step;

    if (g == 0) begin : g_first
      assign src   = item_i;
      assign src_v = valid_i;
    end else begin : g_rest
      assign src   = stage_q[g-1];
      assign src_v = valid_q[g-1];
    end

    always_comb begin
      xs   = $signed(src.x) >>> g;
      ys   = $signed(src.y) >>> g;
      step = signed'({{(Z_W - 32){1'b0}}, atan_turn(5'(g))});
      stage_d[g] = src;
      if (!src.z[Z_W-1]) begin
        stage_d[g].x = src.x - ys;
        stage_d[g].y = src.y + xs;
        stage_d[g].z = src.z - step;
      end else begin
        stage_d[g].x = src.x + ys;
        stage_d[g].y = src.y - xs;
        stage_d[g].z = src.z + step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[g] <= stage_d[g];
      end
    end
  end

  assign valid_o = valid_q[NUM_STAGES-1];
  assign item_o  = stage_q[NUM_STAGES-1];

endmodule

// ===== sv/vrap_finish.sv =====
// Back end: rounding to Q16.16, pivot add with saturation, two-entry output buffer.
// Depends on vrap_pkg and the assertion macros header.
`include "vector_rotate_about_point_core_macros.svh"
module vrap_finish import vrap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  item_t            item_i,
  output logic             room_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [OUT_W-1:0] m_data_o
);

  logic                    valid_q;
  logic signed [RND_W-1:0] rnd_x_d, rnd_y_d, rnd_x_q, rnd_y_q;
  coord_t                  piv_x_q, piv_y_q;
  xy_t                     add_x, add_y;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  coord_t                  sat_x, sat_y;
  logic [OUT_W-1:0]        buf_q [2];
  logic                    wr_ptr_q, rd_ptr_q;
  logic [1:0]              count_q, count_d;
  logic                    push, pop;

  assign room_o = (count_q != 2'd2);

  always_comb begin
    add_x   = item_i.x + XY_W'(ROUND_HALF);
    add_y   = item_i.y + XY_W'(ROUND_HALF);
    rnd_x_d = add_x[XY_W-1:16];
    rnd_y_d = add_y[XY_W-1:16];
  end

  always_comb begin
    sum_x = {rnd_x_q[RND_W-1], rnd_x_q}
          + {{(SUM_W - COORD_W){piv_x_q[COORD_W-1]}}, piv_x_q};
    sum_y = {rnd_y_q[RND_W-1], rnd_y_q}
          + {{(SUM_W - COORD_W){piv_y_q[COORD_W-1]}}, piv_y_q};
    if (sum_x[SUM_W-1:COORD_W-1] == '0 || sum_x[SUM_W-1:COORD_W-1] == '1) begin
      sat_x = sum_x[COORD_W-1:0];
    end else begin
      sat_x = sum_x[SUM_W-1] ? {1'b1, {(COORD_W - 1){1'b0}}} : {1'b0, {(COORD_W - 1){1'b1}}};
    end
    if (sum_y[SUM_W-1:COORD_W-1] == '0 || sum_y[SUM_W-1:COORD_W-1] == '1) begin
      sat_y = sum_y[COORD_W-1:0];
    end else begin
      sat_y = sum_y[SUM_W-1] ? {1'b1, {(COORD_W - 1){1'b0}}} : {1'b0, {(COORD_W - 1){1'b1}}};
    end
  end

  assign push = room_o & valid_q;
  assign pop  = m_valid_o & m_ready_i;

  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (room_o) begin
        valid_q <= valid_i;
      end
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (room_o) begin
      rnd_x_q <= rnd_x_d;
      rnd_y_q <= rnd_y_d;
      piv_x_q <= item_i.pivot_x;
      piv_y_q <= item_i.pivot_y;
    end
    if (push) begin
      buf_q[wr_ptr_q] <= {sat_y, sat_x};
    end
  end

  assign m_valid_o = (count_q != 2'd0);
  assign m_data_o  = buf_q[rd_ptr_q];

  `VRAP_ASSERT_ALWAYS(a_count_range, count_q != 2'd3, "output buffer count out of range")
  `VRAP_ASSERT_SAME(a_no_push_full, push, count_q != 2'd2, "beat written into a full buffer")
  `VRAP_ASSERT_NEXT(a_pop_drains, pop && !push, count_q == $past(count_q) - 2'd1,
                    "buffer count did not drop after a read")

endmodule
